FILE: hw/rtl/scpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_pkg: shared types and constants for the size-class pool allocator
// Holds the beat payload types, the action and status codes, and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int HEAP_BYTES_DEF  = 65536;
  localparam int ALIGN_BYTES_DEF = 8;
  localparam int SMALL_LIMIT_DEF = 128;
  localparam int NUM_CLASSES_DEF = 16;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LARGE = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] size_bytes;
    logic [15:0] old_size_bytes;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [15:0] block_address;
    logic [1:0]  status;
  } rsp_t;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FREE,
    OP_ALLOC_SETUP,
    OP_POP_RD,
    OP_POP_WB,
    OP_CARVE_EVAL,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_TAIL_PUSH,
    OP_HEAP_GET,
    OP_SCAN_RD,
    OP_SCAN_WB,
    OP_LINK_WR,
    OP_SET_HEAD,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] rsp_status;
  } cmd_t;

  typedef struct packed {
    logic       is_alloc;
    logic       is_free;
    logic       free_small;
    logic       alloc_small;
    logic       head_empty;
    logic       fits_total;
    logic       fits_one;
    logic       heap_ok;
    logic       tail_nonzero;
    logic       div_done;
    logic       scan_last;
    logic       scan_hit;
    logic       links_done;
    logic       single;
    logic       tries_left;
  } stat_t;

endpackage

FILE: hw/rtl/size_class_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_pool_allocator_unit: small-block free-list pool allocator
// Serves allocate, free and reallocate requests from sixteen size classes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries a req_t beat (action, sizes,
//   address). Output channel out_valid/out_stall carries one rsp_t beat per
//   request (block address and status).
//   One request is in flight at a time; in_stall is high from acceptance
//   until the result beat is taken.
//   A refill links the blocks of the batch (up to 64) one by one through
//   the link memory port, runs a bit-serial division when the pool holds
//   only part of the batch, and scans the size classes when the heap is
//   exhausted.
//   Reset clears the list heads to empty, the pool and heap counters to
//   zero and refill_batch to 20. The link memory is not cleared.
//   A stalled result beat holds in its register until taken.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_unit #(
  parameter int HEAP_BYTES  = scpa_pkg::HEAP_BYTES_DEF,
  parameter int ALIGN_BYTES = scpa_pkg::ALIGN_BYTES_DEF,
  parameter int SMALL_LIMIT = scpa_pkg::SMALL_LIMIT_DEF,
  parameter int NUM_CLASSES = scpa_pkg::NUM_CLASSES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  scpa_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output scpa_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_wdata
);
  import scpa_pkg::*;

  logic [6:0] refill_batch;
  cmd_t       cmd;
  stat_t      stat;

  // Hold the batch register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      refill_batch <= 7'd20;
    end else if (cfg_we) begin
      refill_batch <= cfg_wdata;
    end
  end

  scpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  scpa_datapath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES),
    .SMALL_LIMIT (SMALL_LIMIT),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (in_data),
    .refill_batch (refill_batch),
    .cmd          (cmd),
    .stat         (stat),
    .rsp          (out_data)
  );

endmodule

FILE: hw/rtl/scpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_datapath: list heads, link memory, pool registers and arithmetic
// Executes one controller command per cycle and reports status flags.
// ----------------------------------------------------------------------------
module scpa_datapath #(
  parameter int HEAP_BYTES  = scpa_pkg::HEAP_BYTES_DEF,
  parameter int ALIGN_BYTES = scpa_pkg::ALIGN_BYTES_DEF,
  parameter int SMALL_LIMIT = scpa_pkg::SMALL_LIMIT_DEF,
  parameter int NUM_CLASSES = scpa_pkg::NUM_CLASSES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  scpa_pkg::req_t req,
  input  logic [6:0]     refill_batch,
  input  scpa_pkg::cmd_t cmd,
  output scpa_pkg::stat_t stat,
  output scpa_pkg::rsp_t rsp
);
  import scpa_pkg::*;

  localparam int BLOCK_COUNT = HEAP_BYTES / ALIGN_BYTES;
  localparam int IW = $clog2(BLOCK_COUNT + 1);       // index incl. null mark
  localparam int AW = $clog2(BLOCK_COUNT);           // memory address
  localparam int HW = $clog2(HEAP_BYTES + 1);        // heap byte values
  localparam int SHW = $clog2(ALIGN_BYTES);
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int BW = $clog2(SMALL_LIMIT + ALIGN_BYTES + 1);
  localparam int WW = HW + 8;                        // wide products
  localparam logic [IW-1:0] NULL_MARK = IW'(BLOCK_COUNT);

  logic [IW-1:0] heads [NUM_CLASSES];
  logic [IW-1:0] links [BLOCK_COUNT];
  logic [IW-1:0] link_rd;

  logic [HW-1:0] pool_start, pool_end, heap_top, heap_total;
  logic [1:0]    action;
  logic [15:0]   size_r, old_r, addr_r;
  logic [BW-1:0] bytes;
  logic [CW-1:0] cls, scan_c;
  logic [6:0]    n, i;
  logic [HW-1:0] chunk;
  logic [HW-1:0] carry_addr;
  logic [15:0]   res_addr;
  logic [1:0]    tries;
  logic [WW-1:0] get;
  // restoring divider: left / bytes
  logic [HW-1:0] rem, quo;
  logic [4:0]    dstep;
  logic [HW-1:0] dnum;
  rsp_t          rsp_r;

  function automatic logic [CW-1:0] class_of(input logic [16:0] s);
    logic [16:0] c;
    begin
      c = (s == '0) ? 17'd0 : 17'((s + 17'(ALIGN_BYTES - 1)) >> SHW) - 17'd1;
      class_of = (c >= 17'(NUM_CLASSES)) ? CW'(NUM_CLASSES - 1) : c[CW-1:0];
    end
  endfunction

  logic [HW-1:0] left;
  logic [WW-1:0] total;
  logic [6:0]    n_lim;
  logic [WW-1:0] heap_room;
  logic [15:0]   free_sz;
  logic [IW-1:0] free_idx;
  logic [WW-1:0] lnk_pos, lnk_nxt;
  logic [IW-1:0] lnk_idx, lnk_nidx;
  logic [WW-1:0] get_next;

  always_comb begin
    left      = pool_end - pool_start;
    total     = WW'(bytes) * WW'(n);
    heap_room = WW'(HEAP_BYTES) - WW'(heap_top);
    n_lim     = (refill_batch == 7'd0) ? 7'd1 :
                (refill_batch > 7'd64) ? 7'd64 : refill_batch;
    free_sz   = (action == ACT_REALLOC) ? old_r : size_r;
    free_idx  = IW'(addr_r >> SHW);
    lnk_pos   = WW'(chunk) + WW'(bytes) * WW'(i);
    lnk_nxt   = lnk_pos + WW'(bytes);
    lnk_idx   = (lnk_pos >> SHW) >= WW'(BLOCK_COUNT) ? NULL_MARK : IW'(lnk_pos >> SHW);
    lnk_nidx  = ((i == n - 7'd1) || ((lnk_nxt >> SHW) > WW'(BLOCK_COUNT))) ? NULL_MARK
                : IW'(lnk_nxt >> SHW);
    carry_addr = HW'(32'(heads[scan_c]) << SHW);
    get_next  = (total << 1)
                + WW'(((32'(heap_total >> 4) + 32'(ALIGN_BYTES - 1)) >> SHW) << SHW);
  end

  always_comb begin
    stat = '0;
    stat.is_alloc     = (action == ACT_ALLOC) || (action == ACT_REALLOC);
    stat.is_free      = (action == ACT_FREE) || (action == ACT_REALLOC);
    stat.free_small   = (32'(free_sz) <= 32'(SMALL_LIMIT));
    stat.alloc_small  = (32'(size_r) <= 32'(SMALL_LIMIT));
    stat.head_empty   = (heads[cls] >= NULL_MARK);
    stat.fits_total   = (WW'(left) >= total);
    stat.fits_one     = (left >= HW'(bytes));
    stat.heap_ok      = (get <= heap_room);
    stat.tail_nonzero = (left != '0);
    stat.div_done     = (dstep == 5'd0);
    stat.scan_last    = (scan_c == CW'(NUM_CLASSES - 1));
    stat.scan_hit     = (heads[scan_c] < NULL_MARK);
    stat.links_done   = (i >= n);
    stat.single       = (n == 7'd1);
    stat.tries_left   = (tries != 2'd3);
  end

  // Link memory: one write or one read per cycle, registered read data.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FREE: begin
        if (free_idx < NULL_MARK) links[free_idx[AW-1:0]] <= heads[class_of(17'(free_sz))];
      end
      OP_TAIL_PUSH: begin
        if (IW'(pool_start >> SHW) < NULL_MARK && (pool_start >> SHW) < HW'(BLOCK_COUNT))
          links[pool_start[SHW+AW-1:SHW]] <= heads[class_of(17'(left))];
      end
      OP_LINK_WR: begin
        if (lnk_idx < NULL_MARK) links[lnk_idx[AW-1:0]] <= lnk_nidx;
      end
      OP_POP_RD: link_rd <= links[heads[cls][AW-1:0]];
      OP_SCAN_RD: link_rd <= links[heads[scan_c][AW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CLASSES; k++) heads[k] <= NULL_MARK;
      pool_start <= '0;
      pool_end   <= '0;
      heap_top   <= '0;
      heap_total <= '0;
      dstep      <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          action <= req.action;
          size_r <= req.size_bytes;
          old_r  <= req.old_size_bytes;
          addr_r <= req.address;
        end
        OP_FREE: begin
          if (free_idx < NULL_MARK) heads[class_of(17'(free_sz))] <= free_idx;
        end
        OP_ALLOC_SETUP: begin
          bytes    <= (size_r == 16'd0) ? BW'(ALIGN_BYTES)
                      : BW'(((32'(size_r) + 32'(ALIGN_BYTES - 1)) >> SHW) << SHW);
          cls      <= class_of(17'(size_r));
          n        <= n_lim;
          tries    <= 2'd0;
          res_addr <= '0;
        end
        OP_POP_WB: begin
          res_addr   <= 16'(32'(heads[cls]) << SHW);
          heads[cls] <= link_rd;
        end
        OP_CARVE_EVAL: begin
          get <= get_next;
          if (WW'(left) >= total) begin
            chunk      <= pool_start;
            pool_start <= pool_start + HW'(total);
          end else if (left >= HW'(bytes)) begin
            dnum  <= left;
            rem   <= '0;
            quo   <= '0;
            dstep <= 5'(HW);
          end
        end
        OP_DIV_STEP: begin
          if ({rem[HW-2:0], dnum[HW-1]} >= HW'(bytes)) begin
            rem <= {rem[HW-2:0], dnum[HW-1]} - HW'(bytes);
            quo <= {quo[HW-2:0], 1'b1};
          end else begin
            rem <= {rem[HW-2:0], dnum[HW-1]};
            quo <= {quo[HW-2:0], 1'b0};
          end
          dnum  <= dnum << 1;
          dstep <= dstep - 5'd1;
        end
        OP_DIV_DONE: begin
          n          <= 7'(quo);
          chunk      <= pool_start;
          pool_start <= pool_start + (left - rem);
        end
        OP_TAIL_PUSH: begin
          get <= get_next;
          if ((pool_start >> SHW) < HW'(BLOCK_COUNT))
            heads[class_of(17'(left))] <= IW'(pool_start >> SHW);
        end
        OP_HEAP_GET: begin
          tries      <= tries + 2'd1;
          if (get <= heap_room) begin
            pool_start <= heap_top;
            heap_top   <= heap_top + HW'(get);
            heap_total <= heap_total + HW'(get);
            pool_end   <= heap_top + HW'(get);
          end else begin
            pool_start <= '0;
            pool_end   <= '0;
            scan_c     <= cls;
          end
        end
        OP_SCAN_RD: begin
          if (!(heads[scan_c] < NULL_MARK) && scan_c != CW'(NUM_CLASSES - 1))
            scan_c <= scan_c + CW'(1);
        end
        OP_SCAN_WB: begin
          heads[scan_c]  <= link_rd;
          pool_start     <= carry_addr;
          pool_end       <= carry_addr + HW'((32'(scan_c) + 1) << SHW);
          tries          <= tries + 2'd1;
        end
        OP_LINK_WR: begin
          i <= i + 7'd1;
        end
        OP_SET_HEAD: begin
          heads[cls] <= ((WW'(chunk) + WW'(bytes)) >> SHW) < WW'(BLOCK_COUNT)
                        ? IW'((WW'(chunk) + WW'(bytes)) >> SHW) : NULL_MARK;
        end
        OP_RESULT: begin
          rsp_r.status        <= cmd.rsp_status;
          rsp_r.block_address <= (cmd.rsp_status == ST_OK && stat.is_alloc)
                                 ? res_addr : 16'd0;
        end
        default: ;
      endcase
      if (cmd.op == OP_DIV_DONE || (cmd.op == OP_CARVE_EVAL && WW'(left) >= total))
        i <= 7'd1;
      if (cmd.op == OP_DIV_DONE) res_addr <= pool_start[15:0];
      if (cmd.op == OP_CARVE_EVAL && WW'(left) >= total) res_addr <= pool_start[15:0];
    end
  end

  assign rsp = rsp_r;

endmodule

FILE: hw/rtl/scpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpa_ctrl: request sequencer
// Walks free, pop, carve, refill and result steps; owns the handshakes.
// ----------------------------------------------------------------------------
module scpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  scpa_pkg::stat_t stat,
  output scpa_pkg::cmd_t  cmd
);
  import scpa_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_FREE  = 15'b000000000000010,
    S_SETUP = 15'b000000000000100,
    S_POPR  = 15'b000000000001000,
    S_POPW  = 15'b000000000010000,
    S_CARVE = 15'b000000000100000,
    S_DIV   = 15'b000000001000000,
    S_DIVD  = 15'b000000010000000,
    S_HEAP  = 15'b000000100000000,
    S_SCANR = 15'b000001000000000,
    S_SCANW = 15'b000010000000000,
    S_LINK  = 15'b000100000000000,
    S_HEAD  = 15'b001000000000000,
    S_RES   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] status, status_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd.op         = OP_NONE;
    cmd.rsp_status = status;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = OP_LOAD;
          state_next  = S_FREE;
          status_next = ST_OK;
        end
      end
      S_FREE: begin
        if (stat.is_free && stat.free_small) cmd.op = OP_FREE;
        if (stat.is_alloc) begin
          state_next = S_SETUP;
        end else begin
          if (stat.is_free && !stat.free_small) status_next = ST_LARGE;
          state_next = S_RES;
        end
      end
      S_SETUP: begin
        if (stat.alloc_small) begin
          cmd.op     = OP_ALLOC_SETUP;
          state_next = S_POPR;
        end else begin
          status_next = ST_LARGE;
          state_next  = S_RES;
        end
      end
      S_POPR: begin
        if (stat.head_empty) begin
          state_next = S_CARVE;
        end else begin
          cmd.op     = OP_POP_RD;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        cmd.op     = OP_POP_WB;
        state_next = S_RES;
      end
      S_CARVE: begin
        cmd.op = OP_CARVE_EVAL;
        if (!stat.tries_left) begin
          cmd.op      = OP_NONE;
          status_next = ST_OOM;
          state_next  = S_RES;
        end else if (stat.fits_total) begin
          state_next = stat.single ? S_RES : S_LINK;
        end else if (stat.fits_one) begin
          state_next = S_DIV;
        end else begin
          state_next = S_HEAP;
          if (stat.tail_nonzero) cmd.op = OP_TAIL_PUSH;
          else cmd.op = OP_CARVE_EVAL;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_DIVD;
        else cmd.op = OP_DIV_STEP;
      end
      S_DIVD: begin
        cmd.op     = OP_DIV_DONE;
        state_next = S_HEAD;
      end
      S_HEAP: begin
        cmd.op     = OP_HEAP_GET;
        state_next = stat.heap_ok ? S_CARVE : S_SCANR;
      end
      S_SCANR: begin
        cmd.op = OP_SCAN_RD;
        if (stat.scan_hit) begin
          state_next = S_SCANW;
        end else if (stat.scan_last) begin
          status_next = ST_OOM;
          state_next  = S_RES;
        end
      end
      S_SCANW: begin
        cmd.op     = OP_SCAN_WB;
        state_next = S_CARVE;
      end
      S_LINK: begin
        if (stat.single) begin
          state_next = S_RES;
        end else if (stat.links_done) begin
          state_next = S_HEAD;
        end else begin
          cmd.op = OP_LINK_WR;
        end
      end
      S_HEAD: begin
        if (stat.single) begin
          state_next = S_RES;
        end else if (!stat.links_done) begin
          state_next = S_LINK;
        end else begin
          cmd.op     = OP_SET_HEAD;
          state_next = S_RES;
        end
      end
      S_RES: begin
        cmd.op     = OP_RESULT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
    end else begin
      state  <= state_next;
      status <= status_next;
    end
  end

endmodule

FILE: bench/size_class_pool_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_pool_allocator_unit_test: self-checking bench for the allocator
// Drives allocate, free and reallocate beats with random gaps and result
// stalls, predicts every result from an internal model of the free lists,
// pool and heap, and walks refill_batch through several settings.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_unit_test;
  import scpa_pkg::*;

  localparam int unsigned ALIGN  = 8;
  localparam int unsigned HEAP   = 65536;
  localparam int unsigned BLOCKS = HEAP / ALIGN;
  localparam int unsigned NCLS   = 16;
  localparam int unsigned SMALL  = 128;
  localparam logic [1:0]  ACT_SPARE = 2'd3;  // unused code: no-op beat

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_data;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;

  size_class_pool_allocator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: list heads, links, pool window and bump heap.
  int unsigned heads [NCLS];
  int unsigned links [BLOCKS];
  int unsigned pool_lo, pool_hi, heap_top, heap_used, batch;

  typedef struct {
    int unsigned addr;
    int unsigned size;
  } live_blk_t;

  req_t      pend_q[$];
  rsp_t      expect_q[$];
  live_blk_t live_q[$];
  int        errors = 0;
  bit        took = 1'b0;
  bit        got_rsp = 1'b0;
  bit        calm = 1'b0;   // no gaps and no stalls while set

  function automatic int unsigned cls_of(int unsigned s);
    int unsigned c;
    c = (s == 0) ? 0 : (s + ALIGN - 1) / ALIGN - 1;
    return (c >= NCLS) ? NCLS - 1 : c;
  endfunction

  function automatic void push_blk(int unsigned a, int unsigned c);
    int unsigned idx;
    idx = a / ALIGN;
    if (idx >= BLOCKS) return;
    links[idx] = heads[c];
    heads[c] = idx;
  endfunction

  function automatic bit pop_blk(int unsigned c, output int unsigned a);
    int unsigned h;
    a = 0;
    h = heads[c];
    if (h >= BLOCKS) return 1'b0;
    heads[c] = links[h];
    a = h * ALIGN;
    return 1'b1;
  endfunction

  // Take up to n blocks from the pool; top it up from the heap, or scan the
  // lists for a spare block once the heap is gone.
  function automatic bit carve_pool(int unsigned bytes, inout int unsigned n,
                                    output int unsigned a);
    int unsigned left, total, want, c, blk;
    bit hit;
    a = 0;
    for (int t = 0; t < 4; t++) begin
      left  = pool_hi - pool_lo;
      total = bytes * n;
      if (left >= total) begin
        a = pool_lo;
        pool_lo += total;
        return 1'b1;
      end
      if (left >= bytes) begin
        n = left / bytes;
        a = pool_lo;
        pool_lo += n * bytes;
        return 1'b1;
      end
      want = 2 * total + (((heap_used >> 4) + ALIGN - 1) / ALIGN) * ALIGN;
      if (left > 0) push_blk(pool_lo, cls_of(left));
      if (want <= HEAP - heap_top) begin
        pool_lo = heap_top;
        heap_top += want;
        heap_used += want;
        pool_hi = pool_lo + want;
        continue;
      end
      pool_lo = 0;
      pool_hi = 0;
      hit = 1'b0;
      for (c = cls_of(bytes); c < NCLS; c++) begin
        if (pop_blk(c, blk)) begin
          pool_lo = blk;
          pool_hi = blk + (c + 1) * ALIGN;
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic bit refill_cls(int unsigned bytes, int unsigned c,
                                    output int unsigned a);
    int unsigned n, chunk, idx, nxt;
    n = batch;
    a = 0;
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    if (!carve_pool(bytes, n, chunk)) return 1'b0;
    a = chunk;
    if (n == 1) return 1'b1;
    for (int unsigned i = 1; i < n; i++) begin
      idx = (chunk + i * bytes) / ALIGN;
      nxt = (i == n - 1) ? BLOCKS : (chunk + (i + 1) * bytes) / ALIGN;
      if (nxt > BLOCKS) nxt = BLOCKS;
      if (idx < BLOCKS) links[idx] = nxt;
    end
    idx = (chunk + bytes) / ALIGN;
    heads[c] = (idx < BLOCKS) ? idx : BLOCKS;
    return 1'b1;
  endfunction

  function automatic rsp_t alloc_rsp(int unsigned size);
    rsp_t r;
    int unsigned bytes, c, a;
    r = '0;
    if (size > SMALL) begin
      r.status = ST_LARGE;
      return r;
    end
    bytes = (size == 0) ? ALIGN : ((size + ALIGN - 1) / ALIGN) * ALIGN;
    c = cls_of(bytes);
    if (pop_blk(c, a) || refill_cls(bytes, c, a)) begin
      r.block_address = a[15:0];
      r.status = ST_OK;
      live_q.push_back('{addr: a & 16'hFFFF, size: size});
    end else begin
      r.status = ST_OOM;
    end
    return r;
  endfunction

  function automatic rsp_t predict_rsp(req_t q);
    rsp_t r;
    r = '0;
    case (q.action)
      ACT_ALLOC: r = alloc_rsp(32'(q.size_bytes));
      ACT_FREE: begin
        if (q.size_bytes > SMALL) r.status = ST_LARGE;
        else push_blk(32'(q.address), cls_of(32'(q.size_bytes)));
      end
      ACT_REALLOC: begin
        if (q.old_size_bytes <= SMALL)
          push_blk(32'(q.address), cls_of(32'(q.old_size_bytes)));
        r = alloc_rsp(32'(q.size_bytes));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Monitor: advance the model on each accepted beat and check results.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < NCLS; i++) heads[i] = BLOCKS;
      for (int i = 0; i < BLOCKS; i++) links[i] = 0;
      pool_lo = 0; pool_hi = 0; heap_top = 0; heap_used = 0;
      batch = 20;
      took <= 1'b0;
      got_rsp <= 1'b0;
    end else begin
      if (cfg_we) batch = 32'(cfg_wdata);
      took <= in_valid && !in_stall;
      if (in_valid && !in_stall) expect_q.push_back(predict_rsp(in_data));
      got_rsp <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", out_data);
        end else begin
          want = expect_q.pop_front();
          if (out_data.block_address !== want.block_address ||
              out_data.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                       want.block_address, want.status,
                       out_data.block_address, out_data.status);
          end
        end
      end
    end
  end

  // Driver: hold a stalled beat, idle for the drawn gap, then send the next.
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      // hold the current beat
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pend_q.size() > 0) begin
      in_data  <= pend_q.pop_front();
      in_valid <= 1'b1;
      gap_left = calm ? 0 : $urandom_range(0, 5);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side: stall each beat for a drawn number of cycles.
  int stall_left = 0;
  always @(negedge clk) begin
    if (got_rsp) stall_left = calm ? 0 : $urandom_range(0, 5);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic req_t mk(logic [1:0] act, logic [15:0] sz, logic [15:0] osz,
                              logic [15:0] adr);
    req_t q;
    q.action = act; q.size_bytes = sz; q.old_size_bytes = osz; q.address = adr;
    return q;
  endfunction

  function automatic logic [15:0] small_size();
    if ($urandom_range(0, 19) == 0) return 16'($urandom_range(129, 65535));
    return 16'($urandom_range(0, SMALL));
  endfunction

  // Mostly well-formed traffic over live blocks, some noise beats.
  function automatic req_t next_req();
    int unsigned pick, k;
    live_blk_t b;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      return mk(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 16'($urandom));
    if (pick < 55 || live_q.size() == 0)
      return mk(ACT_ALLOC, small_size(), 16'($urandom), 16'($urandom));
    k = $urandom_range(0, live_q.size() - 1);
    b = live_q[k];
    live_q.delete(k);
    if (pick < 85) return mk(ACT_FREE, 16'(b.size), 16'($urandom), 16'(b.addr));
    return mk(ACT_REALLOC, small_size(), 16'(b.size), 16'(b.addr));
  endfunction

  task automatic drain();
    while (pend_q.size() > 0 || in_valid || expect_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic run_items(int count);
    for (int i = 0; i < count; i++) begin
      while (pend_q.size() > 1) @(posedge clk);
      pend_q.push_back(next_req());
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [6:0] cfg_vals [6];
    cfg_vals = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd7, 7'd0};
    cfg_vals[5] = 7'($urandom_range(1, 64));
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: size extremes, every action, the odd cases.
    pend_q.push_back(mk(ACT_ALLOC, 16'd0, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_ALLOC, 16'd1, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_ALLOC, 16'd128, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_ALLOC, 16'd129, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pend_q.push_back(mk(ACT_FREE, 16'd8, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_FREE, 16'd129, 16'd0, 16'h0100));
    pend_q.push_back(mk(ACT_FREE, 16'd16, 16'd0, 16'hFFFF));    // unaligned
    pend_q.push_back(mk(ACT_FREE, 16'd16, 16'd0, 16'hFFFF));    // double free
    pend_q.push_back(mk(ACT_ALLOC, 16'd9, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_ALLOC, 16'd16, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_REALLOC, 16'd64, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_REALLOC, 16'd32, 16'hFFFF, 16'h1234));
    pend_q.push_back(mk(ACT_REALLOC, 16'd300, 16'd128, 16'h0800));
    pend_q.push_back(mk(ACT_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pend_q.push_back(mk(ACT_SPARE, 16'd0, 16'd0, 16'd0));
    pend_q.push_back(mk(ACT_ALLOC, 16'd120, 16'd0, 16'd0));
    run_items(120);

    // Each phase first lets the block go idle, then rewrites the batch size.
    foreach (cfg_vals[i]) begin
      drain();
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= cfg_vals[i];
      @(negedge clk) cfg_we <= 1'b0;
      run_items(120);
    end

    while (pend_q.size() > 0 || in_valid || expect_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/scpa_pkg.sv
hw/rtl/scpa_datapath.sv
hw/rtl/scpa_ctrl.sv
hw/rtl/size_class_pool_allocator_unit.sv
bench/size_class_pool_allocator_unit_test.sv
